[hw/rtl/srl_pkg.sv]
// Shared types and constants for the S-record line parser.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package srl_pkg;

    // Input request: one line character or one committed-data read
    typedef struct packed {
        logic       op;
        logic [7:0] char_code;
        logic       line_start;
        logic [7:0] read_index;
    } srl_item_t;

    // Result: record status or read reply
    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [3:0]  record_type;
        logic [31:0] load_address;
        logic [7:0]  data_count;
        logic [7:0]  record_checksum;
        logic [7:0]  read_byte;
    } srl_result_t;

    // Classified request passed from the front end to the back end
    typedef struct packed {
        logic       is_read;
        logic [7:0] read_index;
        logic       line_start;
        logic       is_s;
        logic       type_ok;
        logic [3:0] type_digit;
        logic       hex_ok;
        logic [3:0] hex_val;
    } srl_cmd_t;

    localparam logic       OP_CHAR = 1'b0;
    localparam logic       OP_READ = 1'b1;

    localparam logic       KIND_RECORD = 1'b0;
    localparam logic       KIND_READ   = 1'b1;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_S      = 3'd1;
    localparam logic [2:0] ST_BAD_TYPE  = 3'd2;
    localparam logic [2:0] ST_BAD_LEN   = 3'd3;
    localparam logic [2:0] ST_BAD_HEX   = 3'd4;
    localparam logic [2:0] ST_CHECKSUM  = 3'd5;
    localparam logic [2:0] ST_TRUNCATED = 3'd6;

    localparam logic [3:0] FAIL_TYPE     = 4'd1;
    localparam logic [7:0] FAIL_CHECKSUM = 8'hFC;
    localparam logic [3:0] RESET_TYPE    = 4'd1;

    // Number of address bytes carried by a record type
    function automatic logic [2:0] addr_len(input logic [3:0] rec_type);
        logic [2:0] len;
        case (rec_type)
            4'd3, 4'd7: len = 3'd4;
            4'd2, 4'd8: len = 3'd3;
            default:    len = 3'd2;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

[hw/rtl/srl_front.sv]
// Front end: classifies each incoming request (S check, type digit, hex decode).
// Depends on srl_pkg.
`default_nettype none

module srl_front
    import srl_pkg::*;
(
    input  wire srl_item_t item,
    output srl_cmd_t       cmd
);

    localparam logic [7:0] CH_S      = 8'h53;
    localparam logic [7:0] CH_0      = 8'h30;
    localparam logic [7:0] CH_9      = 8'h39;
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_F = 8'h46;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_F = 8'h66;

    logic [7:0] c;
    logic [7:0] diff_digit;
    logic [7:0] diff_upper;
    logic [7:0] diff_lower;

    always_comb begin
        c          = item.char_code;
        diff_digit = c - CH_0;
        diff_upper = c - CH_UPPER_A + 8'd10;
        diff_lower = c - CH_LOWER_A + 8'd10;

        cmd.is_read    = (item.op == OP_READ);
        cmd.read_index = item.read_index;
        cmd.line_start = item.line_start;
        cmd.is_s       = (c == CH_S);
        cmd.type_digit = diff_digit[3:0];
        cmd.type_ok    = (c >= CH_0) && (c <= CH_9) &&
                         !((diff_digit[3:0] == 4'd4) || (diff_digit[3:0] == 4'd5) ||
                           (diff_digit[3:0] == 4'd6));

        if ((c >= CH_0) && (c <= CH_9)) begin
            cmd.hex_ok  = 1'b1;
            cmd.hex_val = diff_digit[3:0];
        end else if ((c >= CH_UPPER_A) && (c <= CH_UPPER_F)) begin
            cmd.hex_ok  = 1'b1;
            cmd.hex_val = diff_upper[3:0];
        end else if ((c >= CH_LOWER_A) && (c <= CH_LOWER_F)) begin
            cmd.hex_ok  = 1'b1;
            cmd.hex_val = diff_lower[3:0];
        end else begin
            cmd.hex_ok  = 1'b0;
            cmd.hex_val = 4'd0;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/srl_queue.sv]
// Short request queue between the front end and the back end.
// Depends on srl_pkg for the classified request type.
`default_nettype none

module srl_queue
    import srl_pkg::*;
(
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            in_valid,
    output logic           in_ready,
    input  wire srl_cmd_t  in_cmd,
    output logic           out_valid,
    input  wire            out_ready,
    output srl_cmd_t       out_cmd
);

    localparam int DEPTH = 4;
    localparam int PW    = $clog2(DEPTH);

    srl_cmd_t       entry_reg [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [PW:0]    count_reg, count_next;
    logic           push, pop;

    assign in_ready  = (count_reg != (PW+1)'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entry_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

`default_nettype wire

[hw/rtl/srl_back.sv]
// Back end: record parser state machine, two-bank data store and result register.
// Depends on srl_pkg.
`default_nettype none

module srl_back
    import srl_pkg::*;
#(
    parameter int MAX_DATA = 256
) (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            cmd_valid,
    output logic           cmd_ready,
    input  wire srl_cmd_t  cmd,
    output logic           m_valid,
    input  wire            m_ready,
    output srl_result_t    m_data
);

    localparam int IDXW  = (MAX_DATA > 4) ? $clog2(MAX_DATA) : 2;
    localparam int CNTW  = $clog2(MAX_DATA + 1);
    localparam int DEPTH = 2 * (2 ** IDXW);

    localparam logic [2:0] PH_WAIT  = 3'd0;
    localparam logic [2:0] PH_TYPE  = 3'd1;
    localparam logic [2:0] PH_COUNT = 3'd2;
    localparam logic [2:0] PH_ADDR  = 3'd3;
    localparam logic [2:0] PH_DATA  = 3'd4;
    localparam logic [2:0] PH_CHK   = 3'd5;

    logic [2:0]      phase_reg, phase_next;
    logic [IDXW-1:0] bidx_reg, bidx_next;
    logic            odd_reg, odd_next;
    logic [3:0]      hi_reg, hi_next;
    logic [7:0]      sum_reg, sum_next;
    logic [3:0]      ptype_reg, ptype_next;
    logic [31:0]     paddr_reg, paddr_next;
    logic [CNTW-1:0] pcount_reg, pcount_next;
    logic [3:0]      ctype_reg, ctype_next;
    logic [31:0]     caddr_reg, caddr_next;
    logic [CNTW-1:0] ccount_reg, ccount_next;
    logic [7:0]      cchk_reg, cchk_next;
    logic            bank_reg, bank_next;

    logic            m_valid_reg, m_valid_next;
    srl_result_t     out_reg, out_next;
    logic            rb_ok_reg, rb_ok_next;

    logic [7:0]      data_mem [DEPTH];
    logic [7:0]      mem_rd_reg;
    logic            mem_we, mem_re;
    logic [IDXW:0]   mem_waddr, mem_raddr;

    logic            adv, fail, commit, emit;
    logic [2:0]      status;
    logic [7:0]      b;
    logic [2:0]      alen;
    logic [8:0]      data_len;
    logic [IDXW:0]   idx_plus1;

    assign cmd_ready = !m_valid_reg || m_ready;
    assign adv       = cmd_valid && cmd_ready;
    assign m_valid   = m_valid_reg;

    always_comb begin
        m_data           = out_reg;
        m_data.read_byte = rb_ok_reg ? mem_rd_reg : 8'd0;
    end

    always_comb begin
        phase_next  = phase_reg;
        bidx_next   = bidx_reg;
        odd_next    = odd_reg;
        hi_next     = hi_reg;
        sum_next    = sum_reg;
        ptype_next  = ptype_reg;
        paddr_next  = paddr_reg;
        pcount_next = pcount_reg;
        ctype_next  = ctype_reg;
        caddr_next  = caddr_reg;
        ccount_next = ccount_reg;
        cchk_next   = cchk_reg;
        bank_next   = bank_reg;
        fail        = 1'b0;
        commit      = 1'b0;
        status      = ST_OK;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        b           = {hi_reg, cmd.hex_val};
        alen        = addr_len(ptype_reg);
        data_len    = 9'(b) - 9'(alen) - 9'd1;
        idx_plus1   = {1'b0, bidx_reg} + 1'b1;
        mem_waddr   = {~bank_reg, bidx_reg};
        mem_raddr   = {bank_reg, IDXW'(cmd.read_index)};
        rb_ok_next  = 1'b0;

        if (adv) begin
            if (cmd.is_read) begin
                mem_re     = 1'b1;
                rb_ok_next = (9'(cmd.read_index) < 9'(ccount_reg));
            end else if (cmd.line_start) begin
                if (phase_reg != PH_WAIT) begin
                    fail   = 1'b1;
                    status = ST_TRUNCATED;
                end else if (!cmd.is_s) begin
                    fail   = 1'b1;
                    status = ST_NO_S;
                end
                phase_next = cmd.is_s ? PH_TYPE : PH_WAIT;
            end else if (phase_reg == PH_WAIT) begin
                // drop characters outside a record
            end else if (phase_reg == PH_TYPE) begin
                if (cmd.type_ok) begin
                    ptype_next = cmd.type_digit;
                    phase_next = PH_COUNT;
                    bidx_next  = '0;
                    odd_next   = 1'b0;
                    sum_next   = 8'd0;
                end else begin
                    fail       = 1'b1;
                    status     = ST_BAD_TYPE;
                    phase_next = PH_WAIT;
                end
            end else if (!cmd.hex_ok) begin
                fail       = 1'b1;
                status     = ST_BAD_HEX;
                phase_next = PH_WAIT;
            end else if (!odd_reg) begin
                hi_next  = cmd.hex_val;
                odd_next = 1'b1;
            end else begin
                odd_next  = 1'b0;
                bidx_next = idx_plus1[IDXW-1:0];
                case (phase_reg)
                    PH_COUNT: begin
                        sum_next = b;
                        if ((9'(b) < 9'(alen) + 9'd1) || (data_len > 9'(MAX_DATA))) begin
                            fail       = 1'b1;
                            status     = ST_BAD_LEN;
                            phase_next = PH_WAIT;
                        end else begin
                            pcount_next = CNTW'(data_len);
                            paddr_next  = 32'd0;
                            phase_next  = PH_ADDR;
                            bidx_next   = '0;
                        end
                    end
                    PH_ADDR: begin
                        paddr_next = {paddr_reg[23:0], b};
                        sum_next   = sum_reg + b;
                        if (idx_plus1 >= (IDXW+1)'(alen)) begin
                            phase_next = (pcount_reg != '0) ? PH_DATA : PH_CHK;
                            bidx_next  = '0;
                        end
                    end
                    PH_DATA: begin
                        mem_we   = 1'b1;
                        sum_next = sum_reg + b;
                        if (idx_plus1 >= (IDXW+1)'(pcount_reg)) begin
                            phase_next = PH_CHK;
                            bidx_next  = '0;
                        end
                    end
                    PH_CHK: begin
                        if (~sum_reg != b) begin
                            fail   = 1'b1;
                            status = ST_CHECKSUM;
                        end else begin
                            commit      = 1'b1;
                            bank_next   = ~bank_reg;
                            ctype_next  = ptype_reg;
                            caddr_next  = paddr_reg;
                            ccount_next = pcount_reg;
                            cchk_next   = b;
                        end
                        phase_next = PH_WAIT;
                    end
                    default: begin
                        phase_next = PH_WAIT;
                    end
                endcase
            end

            if (fail) begin
                ctype_next  = FAIL_TYPE;
                caddr_next  = 32'd0;
                ccount_next = '0;
                cchk_next   = FAIL_CHECKSUM;
            end
        end

        emit = adv && (fail || commit || cmd.is_read);

        if (adv) begin
            m_valid_next = emit;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end

        out_next                 = out_reg;
        if (adv) begin
            out_next.kind            = cmd.is_read ? KIND_READ : KIND_RECORD;
            out_next.status          = status;
            out_next.record_type     = ctype_next;
            out_next.load_address    = caddr_next;
            out_next.data_count      = 8'(ccount_next);
            out_next.record_checksum = cchk_next;
            out_next.read_byte       = 8'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_WAIT;
            ctype_reg   <= RESET_TYPE;
            caddr_reg   <= 32'd0;
            ccount_reg  <= '0;
            cchk_reg    <= 8'd0;
            bank_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            ctype_reg   <= ctype_next;
            caddr_reg   <= caddr_next;
            ccount_reg  <= ccount_next;
            cchk_reg    <= cchk_next;
            bank_reg    <= bank_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bidx_reg   <= bidx_next;
        odd_reg    <= odd_next;
        hi_reg     <= hi_next;
        sum_reg    <= sum_next;
        ptype_reg  <= ptype_next;
        paddr_reg  <= paddr_next;
        pcount_reg <= pcount_next;
        out_reg    <= out_next;
        if (adv) begin
            rb_ok_reg <= rb_ok_next;
        end
    end

    // Staging bank write; committed bank read, registered
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            data_mem[mem_waddr] <= b;
        end
        if (mem_re) begin
            mem_rd_reg <= data_mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

[hw/rtl/srecord_line_parser.sv]
// S-record line parser: top level joining front end, request queue and back end.
// Depends on srl_pkg, srl_front, srl_queue and srl_back.
//
// Usage:
//   s_valid/s_ready/s_data carry requests: op 0 delivers one character of an
//   S-record line (line_start marks its first character), op 1 reads one
//   byte of the last committed record's data.
//   m_valid/m_ready/m_data carry results: a record status (ok or error
//   code, with the committed type, address, count and checksum) when a
//   record completes or fails, and a reply for every read request.
//   Characters in the middle of a record give no result.
// Timing:
//   One request per cycle is taken in steady state while m_ready stays high. A
//   request is first written into the queue; the back end then takes it from
//   the queue and loads the result register.
// Stalls and reset:
//   When m_ready is low with a result pending, the result register holds and
//   the back end stops; the four-entry queue keeps s_ready high until it fills.
//   Reset (aresetn low, synchronous) empties the queue, drops any pending
//   result and commits an empty type-1 record. Data store contents are not
//   cleared; they are only read below the committed count.
`default_nettype none

module srecord_line_parser
    import srl_pkg::*;
#(
    parameter int MAX_DATA = 256
) (
    input  wire            aclk,
    input  wire            aresetn,
    input  wire            s_valid,
    output logic           s_ready,
    input  wire srl_item_t s_data,
    output logic           m_valid,
    input  wire            m_ready,
    output srl_result_t    m_data
);

    srl_cmd_t front_cmd;
    srl_cmd_t back_cmd;
    logic     back_valid;
    logic     back_ready;

    srl_front u_front (
        .item (s_data),
        .cmd  (front_cmd)
    );

    srl_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_cmd    (front_cmd),
        .out_valid (back_valid),
        .out_ready (back_ready),
        .out_cmd   (back_cmd)
    );

    srl_back #(
        .MAX_DATA (MAX_DATA)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (back_valid),
        .cmd_ready (back_ready),
        .cmd       (back_cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

`default_nettype wire
